### hw/rtl/bec_pkg.sv
// Shared types and constants for the button event classifier.
// No dependencies; imported by button_event_classifier.
`default_nettype none

package bec_pkg;

  // Button count follows from the one-bit button index on the input stream.
  localparam int unsigned NUM_BUTTONS = 2;
  localparam int unsigned BTN_W       = 1;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_LONG    = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_SHORT   = 3'd3,
    EV_RELEASE = 3'd4
  } event_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DOUBLE_PRESS = 2'd1,
    REG_DEBOUNCE     = 2'd2,
    REG_ACTIVE_LOW   = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RST = 16'd300;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;

  localparam logic [1:0] TALLY_MAX = 2'd3;
  localparam logic [1:0] TALLY_DBL = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/button_event_classifier.sv
// Flow: a request is captured in the input register and evaluated there; its
// events go into the result register, which drives the output. Throughput: one
// request per cycle when it yields at most one event and the output is not stalled;
// one that yields two holds the next until the single output port drains them.
// Reset: asynchronous, active low; clears all per-button state and loads the
// register defaults (long 1000, double 300, debounce 50, active high).
// Depends on bec_pkg.
`default_nettype none

module button_event_classifier (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [bec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bec_pkg::CFG_W-1:0]        cfg_data_i,
  // Sample stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [0] button_index, [1] raw_level, [33:2] now_ms, [39:34] zero
  input  wire logic [bec_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Event stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] event_button, [3:1] event_code, [7:4] zero
  output logic [bec_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // last_of_run
  output logic                                  m_axis_tlast
);
  import bec_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] long_ms_q, dbl_ms_q, deb_ms_q;
  logic             act_low_q;

  // Per-button state
  logic              prev_q   [NUM_BUTTONS];
  logic              stable_q [NUM_BUTTONS];
  logic [TIME_W-1:0] lct_q    [NUM_BUTTONS];
  logic              held_q   [NUM_BUTTONS];
  logic [TIME_W-1:0] pst_q    [NUM_BUTTONS];
  logic [TIME_W-1:0] rel_q    [NUM_BUTTONS];
  logic [1:0]        tally_q  [NUM_BUTTONS];
  logic              lr_q     [NUM_BUTTONS];

  // Input register
  logic              in_vld_q;
  logic [BTN_W-1:0]  in_btn_q;
  logic              in_raw_q;
  logic [TIME_W-1:0] in_now_q;

  // Result register: up to two events for one request
  logic [1:0]        res_cnt_q;
  logic [BTN_W-1:0]  res_btn_q;
  event_code_e       res_ev0_q, res_ev1_q;

  // Evaluation of the registered request
  logic              lvl, bounce, edge_det, rise, hold_long, long_held;
  logic [TIME_W-1:0] lct_d, d_deb, d_rel, d_hold;
  logic              held_d, lr_d;
  logic [TIME_W-1:0] pst_d, rel_d;
  logic [1:0]        tally_d;
  logic [1:0]        n_ev;
  event_code_e       ev0, ev1;
  logic              res_free, in_adv, out_take;

  assign lvl   = in_raw_q ^ act_low_q;
  assign lct_d = (lvl != prev_q[in_btn_q]) ? in_now_q : lct_q[in_btn_q];
  assign d_deb  = in_now_q - lct_d;
  assign d_rel  = in_now_q - rel_q[in_btn_q];
  assign d_hold = in_now_q - pst_q[in_btn_q];
  assign bounce = d_deb < {{(TIME_W-CFG_W){1'b0}}, deb_ms_q};
  assign edge_det = !bounce && (lvl != stable_q[in_btn_q]);
  assign rise     = edge_det && lvl;
  // A fresh press has held for zero time.
  assign hold_long = rise ? (long_ms_q == '0)
                          : (d_hold >= {{(TIME_W-CFG_W){1'b0}}, long_ms_q});

  always_comb begin
    held_d  = held_q[in_btn_q];
    lr_d    = lr_q[in_btn_q];
    pst_d   = pst_q[in_btn_q];
    rel_d   = rel_q[in_btn_q];
    tally_d = tally_q[in_btn_q];
    n_ev    = 2'd0;
    ev0     = EV_PRESS;
    ev1     = EV_LONG;
    if (edge_det) begin
      if (lvl) begin
        held_d = 1'b1;
        pst_d  = in_now_q;
        lr_d   = 1'b0;
        if (d_rel < {{(TIME_W-CFG_W){1'b0}}, dbl_ms_q}) begin
          if (tally_q[in_btn_q] != TALLY_MAX) begin
            tally_d = tally_q[in_btn_q] + 2'd1;
          end
        end else begin
          tally_d = 2'd1;
        end
        ev0  = EV_PRESS;
        n_ev = 2'd1;
      end else begin
        if (d_hold >= {{(TIME_W-CFG_W){1'b0}}, long_ms_q}) begin
          ev0 = EV_LONG;
        end else if (tally_q[in_btn_q] == TALLY_DBL) begin
          ev0     = EV_DOUBLE;
          tally_d = 2'd0;
        end else begin
          ev0 = EV_SHORT;
        end
        held_d = 1'b0;
        rel_d  = in_now_q;
        ev1    = EV_RELEASE;
        n_ev   = 2'd2;
      end
    end
    // A sample inside the debounce window reports nothing.
    long_held = !bounce && held_d && hold_long && !lr_d;
    if (long_held) begin
      lr_d = 1'b1;
      if (n_ev == 2'd0) begin
        ev0  = EV_LONG;
        n_ev = 2'd1;
      end else begin
        ev1  = EV_LONG;
        n_ev = 2'd2;
      end
    end
  end

  assign out_take = m_axis_tvalid && m_axis_tready;
  assign res_free = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && m_axis_tready);
  assign in_adv   = in_vld_q && ((n_ev == 2'd0) || res_free);
  assign s_axis_tready = !in_vld_q || in_adv;

  assign m_axis_tvalid = res_cnt_q != 2'd0;
  assign m_axis_tdata  = {4'b0000, res_ev0_q, res_btn_q};
  assign m_axis_tlast  = res_cnt_q == 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q <= LONG_PRESS_RST;
      dbl_ms_q  <= DOUBLE_PRESS_RST;
      deb_ms_q  <= DEBOUNCE_RST;
      act_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LONG_PRESS:   long_ms_q <= cfg_data_i;
        REG_DOUBLE_PRESS: dbl_ms_q  <= cfg_data_i;
        REG_DEBOUNCE:     deb_ms_q  <= cfg_data_i;
        REG_ACTIVE_LOW:   act_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_btn_q <= s_axis_tdata[0];
      in_raw_q <= s_axis_tdata[1];
      in_now_q <= s_axis_tdata[TIME_W+1:2];
    end
  end

  // State is written as the request leaves the input register, so the next
  // request for the same button already sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        prev_q[i]   <= 1'b0;
        stable_q[i] <= 1'b0;
        lct_q[i]    <= '0;
        held_q[i]   <= 1'b0;
        pst_q[i]    <= '0;
        rel_q[i]    <= '0;
        tally_q[i]  <= 2'd0;
        lr_q[i]     <= 1'b0;
      end
    end else if (in_adv) begin
      prev_q[in_btn_q] <= lvl;
      lct_q[in_btn_q]  <= lct_d;
      if (!bounce) begin
        stable_q[in_btn_q] <= lvl;
        held_q[in_btn_q]   <= held_d;
        pst_q[in_btn_q]    <= pst_d;
        rel_q[in_btn_q]    <= rel_d;
        tally_q[in_btn_q]  <= tally_d;
        lr_q[in_btn_q]     <= lr_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (in_adv && (n_ev != 2'd0)) begin
      res_cnt_q <= n_ev;
    end else if (out_take) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && (n_ev != 2'd0)) begin
      res_btn_q <= in_btn_q;
      res_ev0_q <= ev0;
      res_ev1_q <= ev1;
    end else if (out_take) begin
      res_ev0_q <= res_ev1_q;
    end
  end

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for button_event_classifier: drives timed pin samples for both
// buttons, predicts the press, long, double, short and release events, and checks them.
// Depends on bec_pkg and button_event_classifier.
module testbench;
  import bec_pkg::*;

  typedef struct {
    logic        button;
    event_code_e code;
    logic        last;
  } sb_event_t;

  // Scoreboard that tracks the debounce and press state of every button.
  class event_scoreboard;
    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  double_ms;
    logic [CFG_W-1:0]  debounce_ms;
    logic              inv_level;
    logic              prev_lvl[NUM_BUTTONS];
    logic              stable_lvl[NUM_BUTTONS];
    logic              held[NUM_BUTTONS];
    logic              long_done[NUM_BUTTONS];
    logic [TIME_W-1:0] change_t[NUM_BUTTONS];
    logic [TIME_W-1:0] press_t[NUM_BUTTONS];
    logic [TIME_W-1:0] release_t[NUM_BUTTONS];
    logic [1:0]        tally[NUM_BUTTONS];
    sb_event_t         expected_q[$];
    int                errors;

    function new();
      long_ms     = LONG_PRESS_RST;
      double_ms   = DOUBLE_PRESS_RST;
      debounce_ms = DEBOUNCE_RST;
      inv_level   = 1'b0;
      errors      = 0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        prev_lvl[i]   = 1'b0;
        stable_lvl[i] = 1'b0;
        held[i]       = 1'b0;
        long_done[i]  = 1'b0;
        change_t[i]   = '0;
        press_t[i]    = '0;
        release_t[i]  = '0;
        tally[i]      = '0;
      end
    endfunction

    function void write_register(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_LONG_PRESS:   long_ms     = val;
        REG_DOUBLE_PRESS: double_ms   = val;
        REG_DEBOUNCE:     debounce_ms = val;
        REG_ACTIVE_LOW:   inv_level   = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the events caused by one accepted sample request.
    function void note_sample(logic b, logic raw, logic [TIME_W-1:0] now);
      logic              lvl;
      logic [TIME_W-1:0] span;
      event_code_e       events_due[$];
      sb_event_t         ev;
      lvl = raw ^ inv_level;
      if (lvl != prev_lvl[b]) change_t[b] = now;
      span = now - change_t[b];
      if (span < {16'd0, debounce_ms}) begin
        prev_lvl[b] = lvl;
        return;
      end
      if (lvl != stable_lvl[b]) begin
        stable_lvl[b] = lvl;
        if (lvl) begin
          held[b]      = 1'b1;
          press_t[b]   = now;
          long_done[b] = 1'b0;
          span = now - release_t[b];
          if (span < {16'd0, double_ms}) begin
            if (tally[b] != TALLY_MAX) tally[b] = tally[b] + 2'd1;
          end else begin
            tally[b] = 2'd1;
          end
          events_due.push_back(EV_PRESS);
        end else begin
          span = now - press_t[b];
          if (span >= {16'd0, long_ms}) begin
            events_due.push_back(EV_LONG);
          end else if (tally[b] == TALLY_DBL) begin
            events_due.push_back(EV_DOUBLE);
            tally[b] = 2'd0;
          end else begin
            events_due.push_back(EV_SHORT);
          end
          held[b]      = 1'b0;
          release_t[b] = now;
          events_due.push_back(EV_RELEASE);
        end
      end
      span = now - press_t[b];
      if (held[b] && span >= {16'd0, long_ms} && !long_done[b]) begin
        long_done[b] = 1'b1;
        events_due.push_back(EV_LONG);
      end
      prev_lvl[b] = lvl;
      foreach (events_due[i]) begin
        ev.button = b;
        ev.code   = events_due[i];
        ev.last   = (i == events_due.size() - 1);
        expected_q.push_back(ev);
      end
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_event(logic button, logic [2:0] code, logic last);
      sb_event_t exp_ev;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("event button %0d code %0d with none expected",
                                  button, code));
        return;
      end
      exp_ev = expected_q.pop_front();
      if (button !== exp_ev.button)
        report_mismatch($sformatf("event_button %0d, expected %0d", button, exp_ev.button));
      if (code !== exp_ev.code)
        report_mismatch($sformatf("event_code %0d, expected %s", code, exp_ev.code.name()));
      if (last !== exp_ev.last)
        report_mismatch($sformatf("last_of_run %0d, expected %0d", last, exp_ev.last));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  wire                   m_axis_tlast;

  event_scoreboard sb = new();
  logic [TIME_W-1:0] clock_ms = '0;
  int                samples_sent = 0;
  bit                calm = 1'b0;

  button_event_classifier dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Both sides skip their random gaps while calm is set.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic raw_of(logic lvl);
    return lvl ^ sb.inv_level;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_event(m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tlast);
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_sample(logic b, logic raw, logic [TIME_W-1:0] now);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - TIME_W - 2){1'b0}}, now, raw, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(b, raw, now);
    samples_sent++;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops the request line and waits until every predicted event has drained.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_register(idx, val);
  endtask

  task automatic configure(logic [CFG_W-1:0] long_v, logic [CFG_W-1:0] dbl_v,
                           logic [CFG_W-1:0] deb_v, logic al);
    write_reg(REG_LONG_PRESS, long_v);
    write_reg(REG_DOUBLE_PRESS, dbl_v);
    write_reg(REG_DEBOUNCE, deb_v);
    // Upper bits are don't-care for the polarity register.
    write_reg(REG_ACTIVE_LOW, {15'($urandom_range(0, 32767)), al});
    cfg_we_i <= 1'b0;
  endtask

  // Optional bounce, then the level and a second sample one debounce window later.
  task automatic drive_level(logic b, logic lvl, int bounces, logic [TIME_W-1:0] start);
    clock_ms = start;
    for (int i = 0; i < bounces; i++) begin
      send_sample(b, raw_of((i % 2 == 0) ? lvl : !lvl), clock_ms);
      clock_ms += $urandom_range(0, sb.debounce_ms);
    end
    send_sample(b, raw_of(lvl), clock_ms);
    clock_ms += sb.debounce_ms;
    send_sample(b, raw_of(lvl), clock_ms);
  endtask

  task automatic press_cycle(logic b);
    logic [TIME_W-1:0] tp, hold, mid_off, rel_off, rest;
    int                k;
    drive_level(b, 1'b1, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0, clock_ms);
    tp = clock_ms;
    case ($urandom_range(0, 3))
      0: hold = $urandom_range(0, sb.long_ms / 2 + 5);
      1: begin
        // Release right around the long-press threshold.
        hold = {16'd0, sb.long_ms} + $urandom_range(0, 4);
        if (hold >= 2) hold -= 2;
      end
      2: hold = {16'd0, sb.long_ms} + $urandom_range(0, 3000);
      default: hold = $urandom_range(0, 3000);
    endcase
    k = $urandom_range(0, 3);
    mid_off = '0;
    for (int j = 1; j <= k; j++) begin
      mid_off = (hold * j) / (k + 1);
      clock_ms = tp + mid_off;
      send_sample(b, raw_of(1'b1), clock_ms);
    end
    rel_off = (hold >= sb.debounce_ms) ? hold - sb.debounce_ms : hold;
    if (rel_off < mid_off) rel_off = mid_off;
    drive_level(b, 1'b0, ($urandom_range(0, 3) == 0) ? 2 : 0, tp + rel_off);
    case ($urandom_range(0, 2))
      0: rest = $urandom_range(0, sb.double_ms);
      1: rest = {16'd0, sb.double_ms} + $urandom_range(0, 3);
      default: rest = $urandom_range(0, 2000);
    endcase
    clock_ms += rest;
  endtask

  task automatic random_phase(int count);
    int target;
    target = samples_sent + count;
    while (samples_sent < target) begin
      calm = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        8: send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
        9: send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       clock_ms + $urandom_range(0, sb.debounce_ms));
        default: press_cycle(1'($urandom_range(0, 1)));
      endcase
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: bounce filtering, short press, then a double press.
    send_sample(1'b0, 1'b1, 32'd100);
    send_sample(1'b0, 1'b1, 32'd150);
    send_sample(1'b0, 1'b0, 32'd400);
    send_sample(1'b0, 1'b0, 32'd460);
    send_sample(1'b0, 1'b1, 32'd500);
    send_sample(1'b0, 1'b1, 32'd560);
    send_sample(1'b0, 1'b0, 32'd600);
    send_sample(1'b0, 1'b0, 32'd660);
    // Long hold across the timestamp wrap: one long while held, long again on release.
    send_sample(1'b1, 1'b1, 32'hFFFF_FF00);
    send_sample(1'b1, 1'b1, 32'hFFFF_FF40);
    send_sample(1'b1, 1'b1, 32'h0000_0330);
    send_sample(1'b1, 1'b1, 32'h0000_0400);
    send_sample(1'b1, 1'b0, 32'h0000_0500);
    send_sample(1'b1, 1'b0, 32'h0000_0540);
    // Bouncing press where a level change restarts the window.
    send_sample(1'b0, 1'b1, 32'd700);
    send_sample(1'b0, 1'b0, 32'd720);
    send_sample(1'b0, 1'b1, 32'd740);
    send_sample(1'b0, 1'b1, 32'd780);
    send_sample(1'b0, 1'b1, 32'd790);
    clock_ms = 32'd2000;
    random_phase(80);

    // Zero thresholds: every sample passes, a press is long at once.
    configure(16'd0, 16'd0, 16'd0, 1'b1);
    random_phase(90);

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    clock_ms = 32'hFFF0_0000;
    random_phase(90);

    // Short long-press time and a wide window drive the tally to saturation.
    configure(16'd20, 16'hFFFF, 16'd5, 1'b1);
    random_phase(90);

    repeat (2) begin
      configure(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 100)), 1'($urandom_range(0, 1)));
      random_phase(90);
    end

    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/bec_pkg.sv
hw/rtl/button_event_classifier.sv
sim/testbench.sv
